// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers for the top-level RTL file, the one file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mmc3_pkg.sv =====
`timescale 1ns / 1ps

package mmc3_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        display_on;
    } req_t;

    typedef struct packed {
        logic [31:0] prg_banks;
        logic [63:0] chr_banks;
        logic [1:0]  mirroring;
        logic        irq_line;
    } rsp_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Register codes are address bits {15, 14, 13, 0}.
    localparam logic [3:0] REG_SELECT      = 4'b1000;
    localparam logic [3:0] REG_DATA        = 4'b1001;
    localparam logic [3:0] REG_MIRROR      = 4'b1010;
    localparam logic [3:0] REG_IRQ_COUNT   = 4'b1100;
    localparam logic [3:0] REG_IRQ_LATCH   = 4'b1101;
    localparam logic [3:0] REG_IRQ_DISABLE = 4'b1110;
    localparam logic [3:0] REG_IRQ_ENABLE  = 4'b1111;

    // Targets of a data write, chosen by the low nibble of the select register.
    localparam logic [3:0] SEL_CHR_PAIR0 = 4'h0;
    localparam logic [3:0] SEL_CHR_PAIR2 = 4'h1;
    localparam logic [3:0] SEL_CHR4      = 4'h2;
    localparam logic [3:0] SEL_CHR5      = 4'h3;
    localparam logic [3:0] SEL_CHR6      = 4'h4;
    localparam logic [3:0] SEL_CHR7      = 4'h5;
    localparam logic [3:0] SEL_PRG0      = 4'h6;
    localparam logic [3:0] SEL_PRG1      = 4'h7;
    localparam logic [3:0] SEL_PRG2      = 4'h8;
    localparam logic [3:0] SEL_PRG3      = 4'h9;
    localparam logic [3:0] SEL_CHR1      = 4'hA;
    localparam logic [3:0] SEL_CHR3      = 4'hB;

    localparam int SEL_PRG_SWAP_BIT = 6;
    localparam int SEL_CHR_SWAP_BIT = 7;

    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_IS_ROM     = 1'b1;

    // Tail banks for the reset bank count of 32.
    localparam logic [7:0] PRG_TAIL2_RESET = 8'd30;
    localparam logic [7:0] PRG_TAIL1_RESET = 8'd31;

    localparam logic [2:0] CHR_RAM_MASK = 3'h7;

endpackage

// ===== rtl/mmc3_core.sv =====
`timescale 1ns / 1ps

module mmc3_core #(
    parameter int BANK_BITS         = 8,
    parameter int LAST_VISIBLE_LINE = 239
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  mmc3_pkg::req_t     req,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_wdata,
    output mmc3_pkg::rsp_t     rsp_next
);

    localparam int          MASK_WIDE = (1 << BANK_BITS) - 1;
    localparam logic [7:0]  BANK_MASK = MASK_WIDE[7:0];
    localparam logic [8:0]  LAST_LINE = LAST_VISIBLE_LINE[8:0];

    logic [7:0] bank_select_reg, bank_select_next;
    logic [7:0] prg_reg [4];
    logic [7:0] prg_next [4];
    logic [7:0] chr_reg [8];
    logic [7:0] chr_next [8];
    logic [1:0] mirror_reg, mirror_next;
    logic [7:0] irq_count_reg, irq_count_next;
    logic [7:0] irq_reload_reg, irq_reload_next;
    logic       irq_on_reg, irq_on_next;
    logic       irq_pending_reg, irq_pending_next;
    logic       irq_out_reg, irq_out_next;
    logic       chr_is_rom_reg, chr_is_rom_next;

    logic [3:0] reg_code;
    logic       tick_active;
    logic [7:0] count_step;
    logic [7:0] count_load;
    logic [7:0] prg_map [4];
    logic [7:0] chr_lo [4];
    logic [7:0] chr_hi [4];
    logic [7:0] chr_map [8];

    assign reg_code = {req.addr[15:13], req.addr[0]};

    always_comb
    begin
        bank_select_next = bank_select_reg;
        prg_next         = prg_reg;
        chr_next         = chr_reg;
        mirror_next      = mirror_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_on_next      = irq_on_reg;
        irq_pending_next = irq_pending_reg;
        irq_out_next     = irq_out_reg;
        chr_is_rom_next  = chr_is_rom_reg;

        tick_active = (req.scanline <= LAST_LINE) && req.display_on
                      && irq_on_reg && !irq_pending_reg;
        if ((req.scanline == 9'd0) && (irq_count_reg != 8'd0))
        begin
            count_step = irq_count_reg - 8'd1;
        end
        else
        begin
            count_step = irq_count_reg;
        end
        count_load = (count_step == 8'd0) ? irq_reload_reg : count_step;

        if (take)
        begin
            if (req.func == mmc3_pkg::FUNC_TICK)
            begin
                if (tick_active)
                begin
                    if (count_step == 8'd0)
                    begin
                        irq_pending_next = 1'b1;
                        irq_out_next     = 1'b1;
                    end
                    irq_count_next = count_load - 8'd1;
                end
            end
            else
            begin
                case (reg_code)
                    mmc3_pkg::REG_SELECT:
                    begin
                        bank_select_next = req.data;
                    end
                    mmc3_pkg::REG_DATA:
                    begin
                        case (bank_select_reg[3:0])
                            mmc3_pkg::SEL_CHR_PAIR0:
                            begin
                                chr_next[0] = req.data;
                                chr_next[1] = req.data + 8'd1;
                            end
                            mmc3_pkg::SEL_CHR_PAIR2:
                            begin
                                chr_next[2] = req.data;
                                chr_next[3] = req.data + 8'd1;
                            end
                            mmc3_pkg::SEL_CHR4: chr_next[4] = req.data;
                            mmc3_pkg::SEL_CHR5: chr_next[5] = req.data;
                            mmc3_pkg::SEL_CHR6: chr_next[6] = req.data;
                            mmc3_pkg::SEL_CHR7: chr_next[7] = req.data;
                            mmc3_pkg::SEL_PRG0: prg_next[0] = req.data;
                            mmc3_pkg::SEL_PRG1: prg_next[1] = req.data;
                            mmc3_pkg::SEL_PRG2: prg_next[2] = req.data;
                            mmc3_pkg::SEL_PRG3: prg_next[3] = req.data;
                            mmc3_pkg::SEL_CHR1: chr_next[1] = req.data;
                            mmc3_pkg::SEL_CHR3: chr_next[3] = req.data;
                            default:
                            begin
                            end
                        endcase
                    end
                    mmc3_pkg::REG_MIRROR:
                    begin
                        mirror_next = req.data[1:0];
                    end
                    mmc3_pkg::REG_IRQ_COUNT:
                    begin
                        irq_count_next   = req.data;
                        irq_pending_next = 1'b0;
                    end
                    mmc3_pkg::REG_IRQ_LATCH:
                    begin
                        irq_reload_next  = req.data;
                        irq_pending_next = 1'b0;
                    end
                    mmc3_pkg::REG_IRQ_DISABLE:
                    begin
                        irq_on_next      = 1'b0;
                        irq_pending_next = 1'b0;
                        irq_out_next     = 1'b0;
                    end
                    mmc3_pkg::REG_IRQ_ENABLE:
                    begin
                        irq_on_next      = 1'b1;
                        irq_pending_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                mmc3_pkg::CFG_PRG_BANK_COUNT:
                begin
                    prg_next[2] = cfg_wdata[7:0] - 8'd2;
                    prg_next[3] = cfg_wdata[7:0] - 8'd1;
                end
                mmc3_pkg::CFG_CHR_IS_ROM:
                begin
                    chr_is_rom_next = cfg_wdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= 8'd0;
            prg_reg[0]      <= 8'd0;
            prg_reg[1]      <= 8'd1;
            prg_reg[2]      <= mmc3_pkg::PRG_TAIL2_RESET;
            prg_reg[3]      <= mmc3_pkg::PRG_TAIL1_RESET;
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] <= 8'(i);
            end
            mirror_reg      <= 2'd0;
            irq_count_reg   <= 8'd0;
            irq_reload_reg  <= 8'd0;
            irq_on_reg      <= 1'b0;
            irq_pending_reg <= 1'b0;
            irq_out_reg     <= 1'b0;
            chr_is_rom_reg  <= 1'b1;
        end
        else
        begin
            bank_select_reg <= bank_select_next;
            prg_reg         <= prg_next;
            chr_reg         <= chr_next;
            mirror_reg      <= mirror_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_on_reg      <= irq_on_next;
            irq_pending_reg <= irq_pending_next;
            irq_out_reg     <= irq_out_next;
            chr_is_rom_reg  <= chr_is_rom_next;
        end
    end

    // The result reflects the state as it stands after this transaction.
    always_comb
    begin
        if (bank_select_next[mmc3_pkg::SEL_PRG_SWAP_BIT])
        begin
            prg_map[0] = prg_next[2];
            prg_map[2] = prg_next[0];
        end
        else
        begin
            prg_map[0] = prg_next[0];
            prg_map[2] = prg_next[2];
        end
        prg_map[1] = prg_next[1];
        prg_map[3] = prg_next[3];

        if (chr_is_rom_next)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chr_lo[i] = chr_next[i];
                chr_hi[i] = chr_next[4 + i];
            end
        end
        else
        begin
            chr_lo[0] = {5'd0, chr_next[0][2:0] & mmc3_pkg::CHR_RAM_MASK};
            chr_lo[1] = {5'd0, (chr_next[0][2:0] + 3'd1) & mmc3_pkg::CHR_RAM_MASK};
            chr_lo[2] = {5'd0, chr_next[2][2:0] & mmc3_pkg::CHR_RAM_MASK};
            chr_lo[3] = {5'd0, (chr_next[2][2:0] + 3'd1) & mmc3_pkg::CHR_RAM_MASK};
            for (int i = 0; i < 4; i++)
            begin
                chr_hi[i] = {5'd0, chr_next[4 + i][2:0] & mmc3_pkg::CHR_RAM_MASK};
            end
        end

        for (int i = 0; i < 4; i++)
        begin
            if (bank_select_next[mmc3_pkg::SEL_CHR_SWAP_BIT])
            begin
                chr_map[i]     = chr_hi[i];
                chr_map[4 + i] = chr_lo[i];
            end
            else
            begin
                chr_map[i]     = chr_lo[i];
                chr_map[4 + i] = chr_hi[i];
            end
        end

        for (int i = 0; i < 4; i++)
        begin
            rsp_next.prg_banks[8 * i +: 8] = prg_map[i] & BANK_MASK;
        end
        for (int i = 0; i < 8; i++)
        begin
            rsp_next.chr_banks[8 * i +: 8] = chr_map[i] & BANK_MASK;
        end
        rsp_next.mirroring = mirror_next;
        rsp_next.irq_line  = irq_out_next;
    end

endmodule

// ===== rtl/mmc3_obuf.sv =====
`timescale 1ns / 1ps

module mmc3_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mmc3_pkg::rsp_t push_data,
    output logic           skid_full,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mmc3_pkg::rsp_t rsp
);

    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    mmc3_pkg::rsp_t out_data_reg, out_data_next;
    mmc3_pkg::rsp_t skid_data_reg, skid_data_next;
    logic           pop;

    assign pop       = out_valid_reg && !rsp_stall;
    assign skid_full = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // A result that finds the output register occupied waits in the skid entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/mmc3_style_bank_mapper_irq_unit.sv =====
// The result is registered and shows in the next cycle when the output register is free; otherwise it waits its turn.
// Throughput: one transaction per cycle while the skid entry is empty; the mapper state updates in a single pass.
// A two-entry output buffer lets a transaction be accepted while a result waits.
// Reset (rst_n low, asynchronous) clears the buffer and loads the power-on bank,
// mirroring and IRQ state with a bank count of 32 and character ROM selected.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmc3_style_bank_mapper_irq_unit #(
    parameter int BANK_BITS         = 8,
    parameter int LAST_VISIBLE_LINE = 239
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mmc3_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mmc3_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [8:0]     cfg_wdata
);

    logic            take;
    logic            skid_full;
    mmc3_pkg::rsp_t  rsp_next;

    assign req_stall = skid_full;
    assign take      = req_valid && !skid_full;

    mmc3_core #(
        .BANK_BITS         (BANK_BITS),
        .LAST_VISIBLE_LINE (LAST_VISIBLE_LINE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rsp_next  (rsp_next)
    );

    mmc3_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (rsp_next),
        .skid_full (skid_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `ASSERT_CLK_ALWAYS(a_skid_implies_out, req_stall |-> rsp_valid, "skid entry held without a result")
    `ASSERT_CLK(a_skid_holds, (req_stall && rsp_stall) |=> req_stall, "skid entry lost while stalled")
    `ASSERT_CLK(a_fill_skid, (take && rsp_valid && rsp_stall) |=> req_stall, "result dropped on a stalled output")
    `ASSERT_CLK(a_take_gives_result, take |=> rsp_valid, "accepted transaction gave no result")

endmodule

// ===== tb/mmc3_style_bank_mapper_irq_unit_test.sv =====
`timescale 1ns / 1ps

module mmc3_style_bank_mapper_irq_unit_test;
    import mmc3_pkg::*;

    localparam int BANK_BITS = 8;
    localparam int LAST_LINE = 239;
    localparam int FINAL_LINE = 261;
    localparam logic [7:0] BANK_MASK = 8'((1 << BANK_BITS) - 1);
    localparam logic [15:0] ADDR_WINDOW = 16'h8000;
    localparam logic [3:0] REG_MIRROR_SPARE = 4'b1011;
    localparam logic [3:0] SEL_SPARE_FIRST = 4'hC;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    class mapper_shadow;
        logic [8:0] bank_count;
        logic       chr_rom;
        logic [7:0] select_reg;
        logic [7:0] prg_reg[4];
        logic [7:0] chr_reg[8];
        logic [1:0] mirror_reg;
        logic [7:0] irq_cnt;
        logic [7:0] irq_reload;
        logic       irq_enabled;
        logic       irq_pending;
        logic       irq_asserted;
        rsp_t       expected_views[$];
        int         mismatches;

        function new();
            mismatches = 0;
            bank_count = 9'd32;
            chr_rom = 1'b1;
            select_reg = 8'd0;
            prg_reg[0] = 8'd0;
            prg_reg[1] = 8'd1;
            load_tail();
            for (int i = 0; i < 8; i++)
            begin
                chr_reg[i] = 8'(i);
            end
            mirror_reg = 2'd0;
            irq_cnt = 8'd0;
            irq_reload = 8'd0;
            irq_enabled = 1'b0;
            irq_pending = 1'b0;
            irq_asserted = 1'b0;
        endfunction

        function void load_tail();
            prg_reg[2] = 8'(bank_count - 9'd2);
            prg_reg[3] = 8'(bank_count - 9'd1);
        endfunction

        function void write_register(logic index, logic [8:0] value);
            if (index == CFG_PRG_BANK_COUNT)
            begin
                bank_count = value;
                load_tail();
            end
            else
            begin
                chr_rom = value[0];
            end
        endfunction

        function void load_bank(logic [7:0] value);
            case (select_reg[3:0])
                SEL_CHR_PAIR0:
                begin
                    chr_reg[0] = value;
                    chr_reg[1] = value + 8'd1;
                end
                SEL_CHR_PAIR2:
                begin
                    chr_reg[2] = value;
                    chr_reg[3] = value + 8'd1;
                end
                SEL_CHR4: chr_reg[4] = value;
                SEL_CHR5: chr_reg[5] = value;
                SEL_CHR6: chr_reg[6] = value;
                SEL_CHR7: chr_reg[7] = value;
                SEL_PRG0: prg_reg[0] = value;
                SEL_PRG1: prg_reg[1] = value;
                SEL_PRG2: prg_reg[2] = value;
                SEL_PRG3: prg_reg[3] = value;
                SEL_CHR1: chr_reg[1] = value;
                SEL_CHR3: chr_reg[3] = value;
                default: ;
            endcase
        endfunction

        function void bus_write(logic [15:0] addr, logic [7:0] value);
            case ({addr[15], addr[14], addr[13], addr[0]})
                REG_SELECT: select_reg = value;
                REG_DATA: load_bank(value);
                REG_MIRROR: mirror_reg = value[1:0];
                REG_IRQ_COUNT:
                begin
                    irq_cnt = value;
                    irq_pending = 1'b0;
                end
                REG_IRQ_LATCH:
                begin
                    irq_reload = value;
                    irq_pending = 1'b0;
                end
                REG_IRQ_DISABLE:
                begin
                    irq_enabled = 1'b0;
                    irq_pending = 1'b0;
                    irq_asserted = 1'b0;
                end
                REG_IRQ_ENABLE:
                begin
                    irq_enabled = 1'b1;
                    irq_pending = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void scanline_tick(int line, logic shown);
            if (line <= LAST_LINE && shown && irq_enabled && !irq_pending)
            begin
                if (line == 0 && irq_cnt != 8'd0)
                begin
                    irq_cnt = irq_cnt - 8'd1;
                end
                if (irq_cnt == 8'd0)
                begin
                    irq_pending = 1'b1;
                    irq_asserted = 1'b1;
                    irq_cnt = irq_reload;
                end
                irq_cnt = irq_cnt - 8'd1;
            end
        endfunction

        function rsp_t bank_view();
            logic [7:0] prg[4];
            logic [7:0] lo[4];
            logic [7:0] hi[4];
            logic [7:0] ram_mask;
            rsp_t view;
            ram_mask = {5'd0, CHR_RAM_MASK};
            prg[0] = select_reg[SEL_PRG_SWAP_BIT] ? prg_reg[2] : prg_reg[0];
            prg[1] = prg_reg[1];
            prg[2] = select_reg[SEL_PRG_SWAP_BIT] ? prg_reg[0] : prg_reg[2];
            prg[3] = prg_reg[3];
            for (int i = 0; i < 4; i++)
            begin
                lo[i] = chr_reg[i];
                hi[i] = chr_rom ? chr_reg[4 + i] : (chr_reg[4 + i] & ram_mask);
            end
            if (!chr_rom)
            begin
                lo[0] = chr_reg[0] & ram_mask;
                lo[1] = (chr_reg[0] + 8'd1) & ram_mask;
                lo[2] = chr_reg[2] & ram_mask;
                lo[3] = (chr_reg[2] + 8'd1) & ram_mask;
            end
            for (int i = 0; i < 4; i++)
            begin
                view.prg_banks[8 * i +: 8] = prg[i] & BANK_MASK;
                if (select_reg[SEL_CHR_SWAP_BIT])
                begin
                    view.chr_banks[8 * i +: 8] = hi[i] & BANK_MASK;
                    view.chr_banks[8 * (i + 4) +: 8] = lo[i] & BANK_MASK;
                end
                else
                begin
                    view.chr_banks[8 * i +: 8] = lo[i] & BANK_MASK;
                    view.chr_banks[8 * (i + 4) +: 8] = hi[i] & BANK_MASK;
                end
            end
            view.mirroring = mirror_reg;
            view.irq_line = irq_asserted;
            return view;
        endfunction

        function void note_request(req_t item);
            if (item.func == FUNC_TICK)
            begin
                scanline_tick(int'(item.scanline), item.display_on);
            end
            else
            begin
                bus_write(item.addr, item.data);
            end
            expected_views.push_back(bank_view());
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
            begin
                $display("ERROR at %0t: %s", $realtime, msg);
            end
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %h, expected %h", field, got, want));
            end
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_views.size() == 0)
            begin
                report("result transaction with no expectation waiting");
            end
            else
            begin
                want = expected_views.pop_front();
                compare("prg_banks", 64'(got.prg_banks), 64'(want.prg_banks));
                compare("chr_banks", got.chr_banks, want.chr_banks);
                compare("mirroring", 64'(got.mirroring), 64'(want.mirroring));
                compare("irq_line", 64'(got.irq_line), 64'(want.irq_line));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_t       req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_t       rsp;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [8:0] cfg_wdata = 9'd0;

    mapper_shadow shadow;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int issued = 0;
    int cycle_count = 0;

    mmc3_style_bank_mapper_irq_unit #(
        .BANK_BITS(BANK_BITS),
        .LAST_VISIBLE_LINE(LAST_LINE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            shadow.check_result(rsp);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic req_t make_write(logic [3:0] code, logic [7:0] value);
        req_t item;
        item.func = FUNC_WRITE;
        item.addr = 16'($urandom);
        item.addr[15] = code[3];
        item.addr[14] = code[2];
        item.addr[13] = code[1];
        item.addr[0] = code[0];
        item.data = value;
        item.scanline = 9'($urandom_range(FINAL_LINE));
        item.display_on = 1'($urandom);
        return item;
    endfunction

    function automatic req_t make_tick(int line, logic shown);
        req_t item;
        item.func = FUNC_TICK;
        item.addr = 16'($urandom);
        item.data = 8'($urandom);
        item.scanline = 9'(line);
        item.display_on = shown;
        return item;
    endfunction

    task automatic issue(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        shadow.note_request(item);
        issued++;
    endtask

    task automatic quiesce();
        req_valid <= 1'b0;
        while (shadow.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [8:0] count, input logic rom);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_wdata <= count;
        @(posedge clk);
        shadow.write_register(CFG_PRG_BANK_COUNT, count);
        cfg_index <= CFG_CHR_IS_ROM;
        cfg_wdata <= {8'd0, rom};
        @(posedge clk);
        shadow.write_register(CFG_CHR_IS_ROM, {8'd0, rom});
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        issue(make_write(REG_SELECT, {4'hC, SEL_CHR_PAIR0}));
        issue(make_write(REG_DATA, 8'hFF));
        issue(make_write(REG_SELECT, {4'h0, SEL_PRG2}));
        issue(make_write(REG_DATA, 8'h00));
        issue(make_write(REG_SELECT, {4'h8, SEL_CHR1}));
        issue(make_write(REG_DATA, 8'h5A));
        issue(make_write(REG_SELECT, {4'h4, SEL_SPARE_FIRST | 4'h3}));
        issue(make_write(REG_DATA, 8'hA5));
        issue(make_write(REG_MIRROR, 8'hFF));
        issue(make_write(REG_MIRROR_SPARE, 8'h01));
        issue('{func: FUNC_WRITE, addr: ADDR_WINDOW - 16'd1, data: 8'hFF,
                scanline: 9'd0, display_on: 1'b1});
        issue(make_write(REG_IRQ_LATCH, 8'd2));
        issue(make_write(REG_IRQ_COUNT, 8'd0));
        issue(make_write(REG_IRQ_ENABLE, 8'hFF));
        issue(make_tick(0, 1'b1));
        issue(make_tick(1, 1'b1));
        issue(make_write(REG_IRQ_ENABLE, 8'h00));
        issue(make_tick(LAST_LINE + 1, 1'b1));
        issue(make_tick(1, 1'b0));
        issue(make_tick(1, 1'b1));
        issue(make_tick(2, 1'b1));
        issue(make_write(REG_IRQ_DISABLE, 8'h00));
        issue(make_write(REG_IRQ_ENABLE, 8'h00));
        issue(make_tick(0, 1'b1));
        issue(make_tick(FINAL_LINE, 1'b1));
        quiesce();
    endtask

    task automatic run_random(input int count);
        int target;
        int midpoint;
        int line;
        bit paused;
        logic [7:0] sel;
        logic [3:0] code;
        req_t item;
        target = issued + count;
        midpoint = issued + count / 2;
        paused = 1'b0;
        while (issued < target)
        begin
            if (!paused && issued >= midpoint)
            begin
                quiesce();
                paused = 1'b1;
            end
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        sel = 8'($urandom);
                        if ($urandom_range(7) != 0)
                        begin
                            sel[3:0] = 4'($urandom_range(int'(SEL_CHR3)));
                        end
                        else
                        begin
                            sel[3:0] = SEL_SPARE_FIRST | 4'($urandom_range(3));
                        end
                        issue(make_write(REG_SELECT, sel));
                        issue(make_write(REG_DATA, pick_byte()));
                    end
                end
                3, 4, 5:
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        issue(make_write(REG_IRQ_LATCH, 8'($urandom)));
                    end
                    else
                    begin
                        issue(make_write(REG_IRQ_LATCH, 8'($urandom_range(6))));
                    end
                    if ($urandom_range(1) == 0)
                    begin
                        issue(make_write(REG_IRQ_COUNT, 8'($urandom_range(4))));
                    end
                    issue(make_write($urandom_range(5) == 0 ? REG_IRQ_DISABLE
                                                          : REG_IRQ_ENABLE, pick_byte()));
                    line = ($urandom_range(3) == 0) ? $urandom_range(250) : 0;
                    repeat ($urandom_range(4, 24))
                    begin
                        if ($urandom_range(6) == 0)
                        begin
                            case ($urandom_range(3))
                                0: code = REG_IRQ_ENABLE;
                                1: code = REG_IRQ_LATCH;
                                2: code = REG_IRQ_COUNT;
                                default: code = REG_IRQ_DISABLE;
                            endcase
                            issue(make_write(code, 8'($urandom_range(5))));
                        end
                        else
                        begin
                            issue(make_tick(line, $urandom_range(9) != 0));
                            line = (line >= FINAL_LINE) ? 0 : line + 1;
                        end
                    end
                end
                6:
                begin
                    issue(make_write($urandom_range(3) == 0 ? REG_MIRROR_SPARE : REG_MIRROR,
                                     pick_byte()));
                end
                7, 8:
                begin
                    item.func = 1'($urandom);
                    item.addr = 16'($urandom);
                    item.data = 8'($urandom);
                    item.scanline = 9'($urandom_range(FINAL_LINE));
                    item.display_on = 1'($urandom);
                    issue(item);
                end
                default:
                begin
                    issue(make_tick($urandom_range(230, FINAL_LINE), 1'($urandom)));
                end
            endcase
        end
        quiesce();
    endtask

    task automatic run_phase(input logic [8:0] count, input logic rom,
                             input int send_pct, input int recv_pct);
        configure(count, rom);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_random(ITEMS_PER_PHASE);
    endtask

    initial
    begin
        shadow = new();
        send_idle_pct = 38;
        recv_idle_pct = 83;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_phase(9'd2, 1'b0, 38, 83);
        run_phase(9'd256, 1'b1, 38, 83);
        run_phase(9'($urandom_range(3, 254)), 1'b1, 83, 38);
        run_phase(9'd255, 1'b0, 83, 38);
        run_phase(9'd256, 1'b0, 0, 0);
        run_phase(9'd2, 1'b1, 0, 0);
        quiesce();
        repeat (5) @(posedge clk);
        if (shadow.pending() != 0)
        begin
            shadow.report("expectations left over at the end of the run");
        end
        if (shadow.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== mmc3_style_bank_mapper_irq_unit.f =====
+incdir+rtl
rtl/mmc3_pkg.sv
rtl/mmc3_core.sv
rtl/mmc3_obuf.sv
rtl/mmc3_style_bank_mapper_irq_unit.sv
tb/mmc3_style_bank_mapper_irq_unit_test.sv
